@@ hdl/cps_pkg.sv @@
// Shared types, constants and lookup functions for the charlieplex scan unit.
`timescale 1ns / 1ps

package cps_pkg;

  // Field widths
  localparam int ValueW = 7;
  localparam int LineW  = 5;

  // Segment slots of one frame: hundreds pair, tens a..g, units a..g
  localparam int SlotCount = 15;
  localparam int SlotW     = 4;
  localparam int SegCount  = 7;
  localparam int TensBase  = 1;
  localparam int UnitsBase = 8;

  // Number limits
  localparam logic [ValueW-1:0] ValueMax = 7'd100;

  // Default depth of the frame queue between front and back
  localparam int QueueDepthDefault = 2;

  // One bit per segment slot, bit 0 is the hundreds drive
  typedef logic [SlotCount-1:0] slot_mask_t;

  // Queue handshake between the two sides
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // One segment drive
  typedef struct packed {
    logic [LineW-1:0] enable;
    logic [LineW-1:0] level;
  } line_drive_t;

  // Seven-segment pattern, bit 6 is segment a, bit 0 is segment g
  function automatic logic [SegCount-1:0] seg_pattern(input logic [3:0] digit);
    logic [SegCount-1:0] pat;
    pat = 7'b0000000;
    unique case (digit)
      4'd0:    pat = 7'b1111110;
      4'd1:    pat = 7'b0110000;
      4'd2:    pat = 7'b1101101;
      4'd3:    pat = 7'b1111001;
      4'd4:    pat = 7'b0110011;
      4'd5:    pat = 7'b1011011;
      4'd6:    pat = 7'b1011111;
      4'd7:    pat = 7'b1110000;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1111011;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

  // Line drive for each slot; the hundreds slot drives three lines at once
  function automatic line_drive_t slot_drive(input logic [SlotW-1:0] slot);
    line_drive_t d;
    d = '{enable: 5'h00, level: 5'h00};
    unique case (slot)
      4'd0:    d = '{enable: 5'h0E, level: 5'h06};
      4'd1:    d = '{enable: 5'h06, level: 5'h02};
      4'd2:    d = '{enable: 5'h06, level: 5'h04};
      4'd3:    d = '{enable: 5'h0C, level: 5'h08};
      4'd4:    d = '{enable: 5'h0A, level: 5'h08};
      4'd5:    d = '{enable: 5'h12, level: 5'h10};
      4'd6:    d = '{enable: 5'h14, level: 5'h10};
      4'd7:    d = '{enable: 5'h18, level: 5'h10};
      4'd8:    d = '{enable: 5'h03, level: 5'h01};
      4'd9:    d = '{enable: 5'h03, level: 5'h02};
      4'd10:   d = '{enable: 5'h05, level: 5'h01};
      4'd11:   d = '{enable: 5'h05, level: 5'h04};
      4'd12:   d = '{enable: 5'h09, level: 5'h01};
      4'd13:   d = '{enable: 5'h09, level: 5'h08};
      4'd14:   d = '{enable: 5'h11, level: 5'h10};
      default: d = '{enable: 5'h00, level: 5'h00};
    endcase
    return d;
  endfunction

endpackage

@@ hdl/cps_front.sv @@
// Front end: clamps the number, splits it into digits and builds the slot mask.
`timescale 1ns / 1ps

module cps_front (
  input  logic [cps_pkg::ValueW-1:0] value_i,
  output cps_pkg::slot_mask_t        mask_o
);

  logic [cps_pkg::ValueW-1:0] clamped;
  logic                       hundreds;
  logic [14:0]                recip_prod;
  logic [3:0]                 tens;
  logic [3:0]                 units;
  logic [cps_pkg::ValueW-1:0] tens_x10;
  logic [cps_pkg::ValueW-1:0] units_wide;
  logic [cps_pkg::SegCount-1:0] tens_pat;
  logic [cps_pkg::SegCount-1:0] units_pat;

  // Clamp and detect the hundreds case
  assign clamped  = (value_i > cps_pkg::ValueMax) ? cps_pkg::ValueMax : value_i;
  assign hundreds = (clamped == cps_pkg::ValueMax);

  // Divide by ten through the reciprocal 205/2048, exact below 100
  assign recip_prod = {8'd0, clamped} * 15'd205;
  assign tens       = hundreds ? 4'd0 : recip_prod[14:11];
  assign tens_x10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign units_wide = hundreds ? 7'd0 : (clamped - tens_x10);
  assign units      = units_wide[3:0];

  assign tens_pat  = cps_pkg::seg_pattern(tens);
  assign units_pat = cps_pkg::seg_pattern(units);

  // Slot mask: segment a goes first; leading zero blanked except for 100
  always_comb begin
    mask_o    = '0;
    mask_o[0] = hundreds;
    for (int s = 0; s < cps_pkg::SegCount; s++) begin
      mask_o[cps_pkg::TensBase + s]  = tens_pat[cps_pkg::SegCount-1-s] &
                                       (hundreds | (tens != 4'd0));
      mask_o[cps_pkg::UnitsBase + s] = units_pat[cps_pkg::SegCount-1-s];
    end
  end

endmodule

@@ hdl/cps_queue.sv @@
// Short frame queue between the front end and the scan sequencer.
`timescale 1ns / 1ps

module cps_queue #(
  parameter int Depth = cps_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cps_pkg::queue_ctrl_t  ctrl_i,
  input  cps_pkg::slot_mask_t   wr_data_i,
  output cps_pkg::slot_mask_t   rd_data_o,
  output cps_pkg::queue_stat_t  stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cps_pkg::slot_mask_t store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = ctrl_i.push & ~stat_o.full;
  assign do_pop       = ctrl_i.pop & ~stat_o.empty;
  assign rd_data_o    = store_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/cps_back.sv @@
// Scan sequencer: walks the lit slots of a frame, one segment drive per cycle.
`timescale 1ns / 1ps

module cps_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cps_pkg::queue_stat_t           stat_i,
  input  cps_pkg::slot_mask_t            rd_data_i,
  output logic                           pop_o,
  output logic                           result_strobe_o,
  output logic [cps_pkg::LineW-1:0]      line_enable_o,
  output logic [cps_pkg::LineW-1:0]      line_level_o,
  output logic                           frame_end_o
);

  cps_pkg::slot_mask_t      mask_q, mask_d;
  cps_pkg::slot_mask_t      remaining;
  logic [cps_pkg::SlotW-1:0] slot;
  logic                     active;
  logic                     last;
  cps_pkg::line_drive_t     drive;

  logic                     strobe_q;
  cps_pkg::line_drive_t     drive_q;
  logic                     end_q;

  // Lowest lit slot goes next
  always_comb begin
    slot = '0;
    for (int i = cps_pkg::SlotCount - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = cps_pkg::SlotW'(i);
      end
    end
  end

  assign active    = (mask_q != '0);
  assign remaining = mask_q & (mask_q - 1'b1);
  assign last      = active & (remaining == '0);
  assign drive     = cps_pkg::slot_drive(slot);

  // Load the next frame as soon as the current one hands out its last beat
  assign pop_o = (!active || last) && !stat_i.empty;

  always_comb begin
    mask_d = remaining;
    if (pop_o) begin
      mask_d = rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      strobe_q <= active;
    end
  end

  // Result register, payload without reset
  always_ff @(posedge clk_i) begin
    drive_q <= drive;
    end_q   <= last;
  end

  assign result_strobe_o = strobe_q;
  assign line_enable_o   = drive_q.enable;
  assign line_level_o    = drive_q.level;
  assign frame_end_o     = end_q;

endmodule

@@ hdl/charlieplex_two_digit_scan_unit.sv @@
// Top level of the charlieplex two-and-a-half-digit scan unit.
//
// Pulse start with a number on value_i while busy is low; the unit shows
// 0..100 (larger values show as 100) and emits one scan frame: one segment
// drive per clock, each on line_enable_o/line_level_o for exactly one cycle
// with result_strobe_o high, and frame_end_o high on the last beat. A frame
// is 2 to 14 beats long: one per lit segment, plus the hundreds drive for 100.
// With the sequencer idle, a number taken with start goes into the queue, is
// loaded into the sequencer's mask register and its first beat is registered
// onto the outputs; the sequencer emits one beat every cycle, so frames follow
// each other without gaps while the next waits in the queue. Accepted numbers
// wait in a short queue (QueueDepth frames); busy is high while that queue is
// full. Results cannot be held off, so the receiver must take a beat in every
// cycle it is strobed.
`timescale 1ns / 1ps

module charlieplex_two_digit_scan_unit #(
  parameter int QueueDepth = cps_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [cps_pkg::ValueW-1:0] value_i,
  output logic                      result_strobe_o,
  output logic [cps_pkg::LineW-1:0] line_enable_o,
  output logic [cps_pkg::LineW-1:0] line_level_o,
  output logic                      frame_end_o
);

  cps_pkg::slot_mask_t  front_mask;
  cps_pkg::slot_mask_t  queue_head;
  cps_pkg::queue_ctrl_t queue_ctrl;
  cps_pkg::queue_stat_t queue_stat;
  logic                 back_pop;

  // Front end: classify the number into a slot mask
  cps_front u_front (
    .value_i (value_i),
    .mask_o  (front_mask)
  );

  assign busy            = queue_stat.full;
  assign queue_ctrl.push = start & ~busy;
  assign queue_ctrl.pop  = back_pop;

  cps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (queue_ctrl),
    .wr_data_i (front_mask),
    .rd_data_o (queue_head),
    .stat_o    (queue_stat)
  );

  // Back end: scan the frame out
  cps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stat_i          (queue_stat),
    .rd_data_i       (queue_head),
    .pop_o           (back_pop),
    .result_strobe_o (result_strobe_o),
    .line_enable_o   (line_enable_o),
    .line_level_o    (line_level_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

@@ verif/charlieplex_scan_checker.sv @@
// Checker for the charlieplex scan unit: predicts each frame's segment beats and compares them.
`timescale 1ns / 1ps

module charlieplex_scan_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [cps_pkg::ValueW-1:0] value_i,
  input  logic                       result_strobe_i,
  input  logic [cps_pkg::LineW-1:0]  line_enable_i,
  input  logic [cps_pkg::LineW-1:0]  line_level_i,
  input  logic                       frame_end_i,
  input  logic                       drain_done_i,
  output int                         error_count_o,
  output int                         pending_o,
  output int                         frames_o,
  output int                         beats_o,
  output int                         hundreds_o,
  output int                         clamped_o
);

  localparam logic [cps_pkg::LineW-1:0] HundredsEnable = 5'h0E;
  localparam logic [cps_pkg::LineW-1:0] HundredsLevel  = 5'h06;

  // One expected segment drive
  typedef struct packed {
    logic [cps_pkg::LineW-1:0] enable;
    logic [cps_pkg::LineW-1:0] level;
    logic                      last;
  } scan_beat_t;

  scan_beat_t expected_beats[$];
  scan_beat_t frame_buf[14];
  int         frame_len;
  bit         leftovers_checked;

  initial begin
    error_count_o     = 0;
    pending_o         = 0;
    frames_o          = 0;
    beats_o           = 0;
    hundreds_o        = 0;
    clamped_o         = 0;
    frame_len         = 0;
    leftovers_checked = 1'b0;
  end

  // Segment pattern per digit, bit 6 is segment a
  function automatic logic [6:0] digit_segments(input int unsigned d);
    case (d)
      0:       return 7'b1111110;
      1:       return 7'b0110000;
      2:       return 7'b1101101;
      3:       return 7'b1111001;
      4:       return 7'b0110011;
      5:       return 7'b1011011;
      6:       return 7'b1011111;
      7:       return 7'b1110000;
      8:       return 7'b1111111;
      9:       return 7'b1111011;
      default: return 7'b0000000;
    endcase
  endfunction

  // Line indexes {high, low}, zero based; tens a..g then units a..g
  function automatic logic [5:0] segment_lines(input int unsigned slot);
    case (slot)
      0:       return {3'd1, 3'd2};
      1:       return {3'd2, 3'd1};
      2:       return {3'd3, 3'd2};
      3:       return {3'd3, 3'd1};
      4:       return {3'd4, 3'd1};
      5:       return {3'd4, 3'd2};
      6:       return {3'd4, 3'd3};
      7:       return {3'd0, 3'd1};
      8:       return {3'd1, 3'd0};
      9:       return {3'd0, 3'd2};
      10:      return {3'd2, 3'd0};
      11:      return {3'd0, 3'd3};
      12:      return {3'd3, 3'd0};
      default: return {3'd4, 3'd0};
    endcase
  endfunction

  task automatic add_beat(input logic [cps_pkg::LineW-1:0] en,
                          input logic [cps_pkg::LineW-1:0] lvl);
    frame_buf[frame_len] = '{enable: en, level: lvl, last: 1'b0};
    frame_len++;
  endtask

  // Lit segments of one digit, a first
  task automatic add_digit(input int unsigned d, input int unsigned base);
    logic [6:0] segs;
    logic [5:0] pair;
    segs = digit_segments(d);
    for (int s = 0; s < 7; s++) begin
      if (segs[6-s]) begin
        pair = segment_lines(base + s);
        add_beat((5'd1 << pair[5:3]) | (5'd1 << pair[2:0]), 5'd1 << pair[5:3]);
      end
    end
  endtask

  // Whole frame for one accepted number
  task automatic predict_frame(input logic [cps_pkg::ValueW-1:0] raw);
    int unsigned shown;
    frame_len = 0;
    shown = (raw > cps_pkg::ValueMax) ? int'(cps_pkg::ValueMax) : int'(raw);
    if (raw > cps_pkg::ValueMax) clamped_o++;
    if (shown == int'(cps_pkg::ValueMax)) begin
      hundreds_o++;
      add_beat(HundredsEnable, HundredsLevel);
      add_digit(0, 0);
      add_digit(0, 7);
    end else begin
      // leading zero in the tens place stays dark
      if (shown / 10 > 0) add_digit(shown / 10, 0);
      add_digit(shown % 10, 7);
    end
    frame_buf[frame_len-1].last = 1'b1;
    for (int i = 0; i < frame_len; i++) expected_beats.push_back(frame_buf[i]);
    frames_o++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count_o++;
  endtask

  // Predict on each accepted number, compare each strobed beat
  always @(posedge clk_i) begin
    scan_beat_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) predict_frame(value_i);
      if (result_strobe_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("segment beat with no frame pending",
                          {line_enable_i, line_level_i, frame_end_i}, 0);
        end else begin
          want = expected_beats.pop_front();
          beats_o++;
          if (line_enable_i !== want.enable)
            report_mismatch("line_enable_o", line_enable_i, want.enable);
          if (line_level_i !== want.level)
            report_mismatch("line_level_o", line_level_i, want.level);
          if (frame_end_i !== want.last)
            report_mismatch("frame_end_o", frame_end_i, want.last);
        end
      end
      if (drain_done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_beats.size() != 0)
          report_mismatch("beats never delivered", expected_beats.size(), 0);
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

@@ verif/tb_charlieplex_two_digit_scan_unit.sv @@
// Testbench top for the charlieplex scan unit: clock, reset, number stimulus and verdict.
`timescale 1ns / 1ps

module tb_charlieplex_two_digit_scan_unit;

  localparam int RandomItems = 400;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [cps_pkg::ValueW-1:0] value_i;
  logic                       result_strobe_o;
  logic [cps_pkg::LineW-1:0]  line_enable_o;
  logic [cps_pkg::LineW-1:0]  line_level_o;
  logic                       frame_end_o;
  logic                       drain_done;

  int error_count;
  int pending_beats;
  int frame_total;
  int beat_total;
  int hundreds_total;
  int clamped_total;
  int cycle_count;

  charlieplex_two_digit_scan_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .result_strobe_o(result_strobe_o),
    .line_enable_o  (line_enable_o),
    .line_level_o   (line_level_o),
    .frame_end_o    (frame_end_o)
  );

  charlieplex_scan_checker scan_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .value_i        (value_i),
    .result_strobe_i(result_strobe_o),
    .line_enable_i  (line_enable_o),
    .line_level_i   (line_level_o),
    .frame_end_i    (frame_end_o),
    .drain_done_i   (drain_done),
    .error_count_o  (error_count),
    .pending_o      (pending_beats),
    .frames_o       (frame_total),
    .beats_o        (beat_total),
    .hundreds_o     (hundreds_total),
    .clamped_o      (clamped_total)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_charlieplex_two_digit_scan_unit: done, errors");
      $finish;
    end
  end

  // Present one number at a falling edge and hold it until a rising edge takes it;
  // busy only moves at rising edges, so its value now is what the next edge sees.
  task automatic send_number(input logic [cps_pkg::ValueW-1:0] v);
    bit taken;
    start   <= 1'b1;
    value_i <= v;
    do begin
      taken = !busy;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // Random pause with junk on the value bus
  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 12) begin
      start   <= 1'b0;
      value_i <= cps_pkg::ValueW'($urandom);
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [cps_pkg::ValueW-1:0] directed_values[24];
    logic [cps_pkg::ValueW-1:0] v;
    directed_values = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9,
                        7'd10, 7'd11, 7'd20, 7'd37, 7'd46, 7'd58, 7'd69, 7'd79,
                        7'd99, 7'd100, 7'd101, 7'd127, 7'd64, 7'd85};
    start      = 1'b0;
    value_i    = '0;
    drain_done = 1'b0;
    rst_ni     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: single digits, leading-zero blanking, 99, 100 and clamped values
    foreach (directed_values[i]) begin
      send_number(directed_values[i]);
      maybe_pause(1'b1);
    end

    // Random: mostly in range, some above; a long back-to-back stretch in the middle
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 99) < 8) v = cps_pkg::ValueW'($urandom_range(101, 127));
      else                           v = cps_pkg::ValueW'($urandom_range(0, 100));
      send_number(v);
      maybe_pause(!(i >= 120 && i < 220));
    end
    start <= 1'b0;

    // Drain
    while (pending_beats != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk_i);

    $display("summary: %0d frames, %0d segment beats checked", frame_total, beat_total);
    $display("summary: %0d frames at one hundred, %0d of them clamped from above",
             hundreds_total, clamped_total);
    if (error_count == 0) begin
      $display("tb_charlieplex_two_digit_scan_unit: done, clean");
    end else begin
      $display("tb_charlieplex_two_digit_scan_unit: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/cps_pkg.sv
hdl/cps_front.sv
hdl/cps_queue.sv
hdl/cps_back.sv
hdl/charlieplex_two_digit_scan_unit.sv
verif/charlieplex_scan_checker.sv
verif/tb_charlieplex_two_digit_scan_unit.sv
